@@ rtl/core/lrn_pkg.sv @@
`default_nettype none

package lrn_pkg;

   // build-time defaults for the top-level parameters
   localparam int PLANE_MAX_DEF = 4096;
   localparam int HALF_MAX_DEF  = 4;

   // command fields sized for the widest legal parameters
   localparam int CMD_POS_W  = 16;
   localparam int CMD_SLOT_W = 5;

   localparam int DEPTH_MAX  = 4096;
   localparam int LOG_BITS   = 24;
   localparam int FIFO_DEPTH = 2;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_DRAIN  = 1'b1;

   typedef enum logic [2:0] {
      CSR_CHANNEL_COUNT = 3'd0,
      CSR_PLANE_SIZE    = 3'd1,
      CSR_WINDOW_SIZE   = 3'd2,
      CSR_ALPHA_SCALE   = 3'd3,
      CSR_BETA_EXPONENT = 3'd4,
      CSR_BIAS_K        = 3'd5
   } lrn_csr_type;

   localparam logic [12:0] CHANNEL_COUNT_RST = 13'd1;
   localparam logic [12:0] PLANE_SIZE_RST    = 13'd1;
   localparam logic [3:0]  WINDOW_SIZE_RST   = 4'd5;
   localparam logic [31:0] ALPHA_SCALE_RST   = 32'd429497;
   localparam logic [17:0] BETA_EXPONENT_RST = 18'd49152;
   localparam logic [23:0] BIAS_K_RST        = 24'd131072;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] sample;
   } lrn_req_type;

   typedef struct packed {
      logic signed [15:0] value;
      logic               last;
   } lrn_rsp_type;

   typedef struct packed {
      logic [12:0] channel_count;
      logic [12:0] plane_size;
      logic [3:0]  window_size;
   } lrn_shape_type;

   typedef struct packed {
      logic [31:0] alpha_scale;
      logic [17:0] beta_exponent;
      logic [23:0] bias_k;
   } lrn_coef_type;

   typedef struct packed {
      logic                  is_drain;
      logic signed [15:0]    x;
      logic [CMD_SLOT_W-1:0] old_slot;
      logic [CMD_SLOT_W-1:0] y_slot;
      logic [CMD_POS_W-1:0]  pos;
      logic                  first;
      logic                  old_valid;
      logic                  emit;
      logic                  y_is_x;
      logic                  last;
   } lrn_cmd_type;

   typedef enum logic [2:0] {
      B_IDLE, B_READ, B_SQUARE, B_SUM, B_BASE, B_START, B_NORM, B_OUT
   } lrn_back_state_type;

   typedef enum logic [3:0] {
      N_IDLE, N_LZC, N_LOG, N_EXP, N_SPLIT, N_POW, N_SCALE, N_ROUND, N_DONE
   } lrn_norm_state_type;

   typedef logic [31:0] lrn_root_tab_type [LOG_BITS+1];

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bit_v;
      n     = n_in;
      res   = 64'd0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 64'd0) begin
         if (n >= res + bit_v) begin
            n   = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // floor(2^30 * 2^(2^-i)) by repeated square roots
   function automatic lrn_root_tab_type build_roots();
      lrn_root_tab_type t;
      logic [63:0]      r;
      t[0] = 32'd0;
      r    = isqrt64(64'd2 << 60);
      t[1] = r[31:0];
      for (int i = 2; i <= LOG_BITS; i++) begin
         r    = isqrt64(r << 30);
         t[i] = r[31:0];
      end
      return t;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/cross_channel_lrn.sv @@
// the power step is skipped for a zero sample, zero beta or zero base; a transaction that
// only updates the sums returns to idle after the sum write, without normalisation
// the back end works on one transaction at a time while the front keeps queueing commands,
// paced by the shared power unit (6 search steps, 24 log2 squarings, 24 exp2 root products)
// reset: synchronous, active high; registers take their documented defaults and the
// counters clear; the plane ring and sum memories are not cleared
`default_nettype none

module cross_channel_lrn #(
   parameter int PLANE_MAX = lrn_pkg::PLANE_MAX_DEF,
   parameter int HALF_MAX  = lrn_pkg::HALF_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lrn_pkg::lrn_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lrn_pkg::lrn_rsp_type rsp_data
);
   import lrn_pkg::*;

   // configuration registers
   logic [12:0] channel_count_ff;
   logic [12:0] plane_size_ff;
   logic [3:0]  window_size_ff;
   logic [31:0] alpha_scale_ff;
   logic [17:0] beta_exponent_ff;
   logic [23:0] bias_k_ff;
   logic        restart;

   lrn_shape_type shape;
   lrn_coef_type  coef;
   lrn_cmd_type   push_cmd, head;
   logic          push, pop, full, empty;

   // any write to a known register restarts the tensor
   always_comb begin
      restart = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT, CSR_PLANE_SIZE, CSR_WINDOW_SIZE,
            CSR_ALPHA_SCALE, CSR_BETA_EXPONENT, CSR_BIAS_K: restart = 1'b1;
            default: restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CHANNEL_COUNT_RST;
         plane_size_ff    <= PLANE_SIZE_RST;
         window_size_ff   <= WINDOW_SIZE_RST;
         alpha_scale_ff   <= ALPHA_SCALE_RST;
         beta_exponent_ff <= BETA_EXPONENT_RST;
         bias_k_ff        <= BIAS_K_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[12:0];
            CSR_PLANE_SIZE:    plane_size_ff    <= csr_wdata[12:0];
            CSR_WINDOW_SIZE:   window_size_ff   <= csr_wdata[3:0];
            CSR_ALPHA_SCALE:   alpha_scale_ff   <= csr_wdata;
            CSR_BETA_EXPONENT: beta_exponent_ff <= csr_wdata[17:0];
            CSR_BIAS_K:        bias_k_ff        <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   assign shape = '{channel_count: channel_count_ff, plane_size: plane_size_ff,
                    window_size: window_size_ff};
   assign coef  = '{alpha_scale: alpha_scale_ff, beta_exponent: beta_exponent_ff,
                    bias_k: bias_k_ff};

   // front: tracks tensor position, classifies each transaction, issues commands
   lrn_front #(
      .PLANE_MAX (PLANE_MAX),
      .HALF_MAX  (HALF_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .shape     (shape),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fifo_full (full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // short command queue decoupling the two halves
   lrn_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   // back: plane ring, running sums, normalisation and the output register
   lrn_back #(
      .PLANE_MAX (PLANE_MAX),
      .HALF_MAX  (HALF_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef),
      .fifo_empty (empty),
      .fifo_pop   (pop),
      .cmd        (head),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/core/lrn_front.sv @@
`default_nettype none

module lrn_front #(
   parameter int PLANE_MAX = lrn_pkg::PLANE_MAX_DEF,
   parameter int HALF_MAX  = lrn_pkg::HALF_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  lrn_pkg::lrn_shape_type shape,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lrn_pkg::lrn_req_type  req_data,
   input  logic                  fifo_full,
   output logic                  push,
   output lrn_pkg::lrn_cmd_type  push_cmd
);
   import lrn_pkg::*;

   localparam int POS_W = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1;
   localparam int SS_W  = $clog2(PLANE_MAX + 1);

   logic [11:0]           in_depth_ff, in_depth_in, out_depth_ff, out_depth_in;
   logic [POS_W-1:0]      in_pos_ff, in_pos_in, out_pos_ff, out_pos_in;
   logic [CMD_SLOT_W-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic                  done_ff, done_in;

   logic [12:0]           dd;
   logic [SS_W-1:0]       ss;
   logic [3:0]            half;
   logic [CMD_SLOT_W-1:0] ring;
   logic                  accept, take_sample, take_drain, emit, last;
   logic                  in_wrap, out_wrap, in_end;
   logic [CMD_SLOT_W:0]   old_sum;
   logic [CMD_SLOT_W-1:0] old_slot;

   always_comb begin
      if (shape.channel_count == 13'd0) dd = 13'd1;
      else if (32'(shape.channel_count) > DEPTH_MAX) dd = 13'(DEPTH_MAX);
      else dd = shape.channel_count;
      if (shape.plane_size == 13'd0) ss = SS_W'(1);
      else if (32'(shape.plane_size) > PLANE_MAX) ss = SS_W'(PLANE_MAX);
      else ss = SS_W'(shape.plane_size);
      if ({1'b0, shape.window_size[3:1]} > 4'(HALF_MAX)) half = 4'(HALF_MAX);
      else half = {1'b0, shape.window_size[3:1]};
      ring = CMD_SLOT_W'({half, 1'b1});
   end

   assign req_stall   = fifo_full;
   assign accept      = req_valid && !req_stall;
   assign take_sample = accept && (req_data.kind == KIND_SAMPLE) && !done_ff;
   assign take_drain  = accept && (req_data.kind == KIND_DRAIN) && done_ff;
   assign in_wrap     = (32'(in_pos_ff) + 32'd1) >= 32'(ss);
   assign out_wrap    = (32'(out_pos_ff) + 32'd1) >= 32'(ss);
   assign in_end      = (13'(in_depth_ff) + 13'd1) >= dd;
   assign last        = (13'(out_depth_ff) == dd - 13'd1) && (32'(out_pos_ff) == 32'(ss) - 32'd1);
   assign emit        = take_sample ? (in_depth_ff >= 12'(half)) : take_drain;
   assign push        = take_sample || take_drain;

   // slot of depth o-half-1, which is o+half modulo the ring
   always_comb begin
      old_sum = (CMD_SLOT_W + 1)'(out_slot_ff) + (CMD_SLOT_W + 1)'(half);
      if (old_sum >= (CMD_SLOT_W + 1)'(ring)) old_sum = old_sum - (CMD_SLOT_W + 1)'(ring);
      old_slot = old_sum[CMD_SLOT_W-1:0];
   end

   always_comb begin
      push_cmd.is_drain = take_drain;
      push_cmd.x        = req_data.sample;
      push_cmd.old_slot = take_drain ? old_slot : in_slot_ff;
      push_cmd.y_slot   = out_slot_ff;
      push_cmd.pos      = take_drain ? CMD_POS_W'(out_pos_ff) : CMD_POS_W'(in_pos_ff);
      push_cmd.first    = take_sample && (in_depth_ff == 12'd0);
      push_cmd.old_valid = take_drain ? (out_depth_ff >= 12'(half) + 12'd1)
                                      : (in_depth_ff >= 12'(ring));
      push_cmd.emit     = emit;
      push_cmd.y_is_x   = take_sample && (half == 4'd0);
      push_cmd.last     = last;
   end

   always_comb begin
      in_depth_in  = in_depth_ff;
      in_pos_in    = in_pos_ff;
      in_slot_in   = in_slot_ff;
      out_depth_in = out_depth_ff;
      out_pos_in   = out_pos_ff;
      out_slot_in  = out_slot_ff;
      done_in      = done_ff;
      if (take_sample) begin
         if (in_wrap) begin
            in_pos_in   = '0;
            in_depth_in = in_depth_ff + 12'd1;
            in_slot_in  = (in_slot_ff + 1'b1 == ring) ? '0 : in_slot_ff + 1'b1;
            if (in_end) done_in = 1'b1;
         end else begin
            in_pos_in = in_pos_ff + 1'b1;
         end
      end
      if (emit) begin
         if (out_wrap) begin
            out_pos_in   = '0;
            out_depth_in = out_depth_ff + 12'd1;
            out_slot_in  = (out_slot_ff + 1'b1 == ring) ? '0 : out_slot_ff + 1'b1;
         end else begin
            out_pos_in = out_pos_ff + 1'b1;
         end
      end
      if (restart || (emit && last)) begin
         in_depth_in  = '0;
         in_pos_in    = '0;
         in_slot_in   = '0;
         out_depth_in = '0;
         out_pos_in   = '0;
         out_slot_in  = '0;
         done_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_depth_ff  <= '0;
         in_pos_ff    <= '0;
         in_slot_ff   <= '0;
         out_depth_ff <= '0;
         out_pos_ff   <= '0;
         out_slot_ff  <= '0;
         done_ff      <= 1'b0;
      end else begin
         in_depth_ff  <= in_depth_in;
         in_pos_ff    <= in_pos_in;
         in_slot_ff   <= in_slot_in;
         out_depth_ff <= out_depth_in;
         out_pos_ff   <= out_pos_in;
         out_slot_ff  <= out_slot_in;
         done_ff      <= done_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/lrn_fifo.sv @@
`default_nettype none

module lrn_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lrn_pkg::lrn_cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output lrn_pkg::lrn_cmd_type head,
   output logic                 empty
);
   import lrn_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   lrn_cmd_type      slots_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full  = (count_ff == (PTR_W + 1)'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

@@ rtl/core/lrn_norm.sv @@
`default_nettype none

module lrn_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] x,
   input  logic [34:0]        base,
   input  logic [17:0]        beta,
   output logic               done,
   output logic signed [15:0] value
);
   import lrn_pkg::*;

   localparam lrn_root_tab_type ROOTS = build_roots();

   lrn_norm_state_type state_ff, state_in;
   logic [4:0]         step_ff, step_in;
   logic signed [15:0] x_ff;
   logic [17:0]        beta_ff;
   logic [34:0]        m_ff;
   logic [5:0]         z_ff;
   logic [23:0]        frac_ff;
   logic signed [48:0] prod_e_ff;
   logic signed [8:0]  ip_ff;
   logic [23:0]        f_ff;
   logic [31:0]        g_ff;
   logic [47:0]        scl_ff;
   logic signed [15:0] value_ff;

   logic               special;
   logic signed [15:0] special_value;
   logic [5:0]         shamt;
   logic               top_zero;
   logic [34:0]        lz_m;
   logic [63:0]        sq;
   logic [31:0]        sq_t;
   logic signed [29:0] lg;
   logic signed [48:0] prod_e, neg_e, ip_full;
   logic [63:0]        gp;
   logic [15:0]        ax;
   logic [5:0]         rshift;
   logic [49:0]        mag;
   logic signed [15:0] result;

   assign special = (x == 16'sd0) || (beta == 18'd0) || (base == 35'd0);

   always_comb begin
      if (x == 16'sd0) special_value = 16'sd0;
      else if (beta == 18'd0) special_value = x;
      else if (x > 16'sd0) special_value = 16'sd32767;
      else special_value = -16'sd32768;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         N_IDLE:  if (start) state_in = special ? N_DONE : N_LZC;
         N_LZC:   if (step_ff == 5'd5) state_in = N_LOG;
         N_LOG:   if (step_ff == 5'(LOG_BITS - 1)) state_in = N_EXP;
         N_EXP:   state_in = N_SPLIT;
         N_SPLIT: state_in = N_POW;
         N_POW:   if (step_ff == 5'(LOG_BITS - 1)) state_in = N_SCALE;
         N_SCALE: state_in = N_ROUND;
         N_ROUND: state_in = N_DONE;
         N_DONE:  state_in = N_IDLE;
         default: state_in = N_IDLE;
      endcase
      step_in = (state_in != state_ff) ? 5'd0 : step_ff + 5'd1;
   end

   // outputs
   always_comb begin
      done  = (state_ff == N_DONE);
      value = value_ff;
   end

   // leading-one search in halving steps, then log2 fraction by squaring
   always_comb begin
      shamt    = 6'd32 >> step_ff;
      top_zero = (m_ff >> (6'd35 - shamt)) == 35'd0;
      lz_m     = top_zero ? (m_ff << shamt) : m_ff;
      sq       = 64'(m_ff[31:0]) * 64'(m_ff[31:0]);
      sq_t     = sq[61:30];
      lg       = $signed({6'(6'd18 - z_ff), frac_ff});
      prod_e   = $signed(49'(beta_ff)) * 49'(lg);
      neg_e    = -prod_e_ff;
      ip_full  = neg_e >>> 40;
      gp       = 64'(g_ff) * 64'(ROOTS[step_ff + 5'd1]);
      ax       = (x_ff < 16'sd0) ? 16'(-x_ff) : 16'(x_ff);
      rshift   = 6'(9'sd30 - ip_ff);
      if (ip_ff >= 9'sd16) mag = 50'd1 << 20;
      else if (ip_ff < -9'sd17) mag = 50'd0;
      else mag = (50'(scl_ff) + (50'd1 << (rshift - 6'd1))) >> rshift;
      if (x_ff > 16'sd0) result = (mag > 50'd32767) ? 16'sd32767 : $signed(mag[15:0]);
      else result = (mag > 50'd32768) ? -16'sd32768 : -$signed(mag[15:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         step_ff  <= 5'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         N_IDLE: begin
            // the finished value is held until the next start
            if (start) begin
               x_ff     <= x;
               beta_ff  <= beta;
               m_ff     <= base;
               z_ff     <= 6'd0;
               frac_ff  <= 24'd0;
               value_ff <= special_value;
            end
         end
         N_LZC: begin
            if (top_zero) z_ff <= z_ff + shamt;
            m_ff <= (step_ff == 5'd5) ? (lz_m >> 4) : lz_m;
         end
         N_LOG: begin
            if (sq_t[31]) begin
               m_ff <= 35'(sq_t >> 1);
               frac_ff[5'(LOG_BITS - 1) - step_ff] <= 1'b1;
            end else begin
               m_ff <= 35'(sq_t);
            end
         end
         N_EXP: prod_e_ff <= prod_e;
         N_SPLIT: begin
            ip_ff <= 9'(ip_full);
            f_ff  <= neg_e[39:16];
            g_ff  <= 32'd1 << 30;
         end
         N_POW: begin
            if (f_ff[5'(LOG_BITS - 1) - step_ff]) g_ff <= gp[61:30];
         end
         N_SCALE: scl_ff <= 48'(ax) * 48'(g_ff);
         N_ROUND: value_ff <= result;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/lrn_back.sv @@
`default_nettype none

module lrn_back #(
   parameter int PLANE_MAX = lrn_pkg::PLANE_MAX_DEF,
   parameter int HALF_MAX  = lrn_pkg::HALF_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lrn_pkg::lrn_coef_type coef,
   input  logic                 fifo_empty,
   output logic                 fifo_pop,
   input  lrn_pkg::lrn_cmd_type cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lrn_pkg::lrn_rsp_type rsp_data
);
   import lrn_pkg::*;

   localparam int RING_MAX = 2 * HALF_MAX + 1;
   localparam int POS_W    = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1;
   localparam int ADDR_W   = (RING_MAX * PLANE_MAX > 1) ? $clog2(RING_MAX * PLANE_MAX) : 1;

   lrn_back_state_type state_ff, state_in;
   lrn_cmd_type        cmd_ff;

   logic signed [15:0] store_mem [RING_MAX * PLANE_MAX];
   logic [33:0]        sums_mem [PLANE_MAX];

   logic signed [15:0] old_rd_ff, y_rd_ff, y_ff;
   logic [33:0]        s_rd_ff, sum_ff, sum_in;
   logic [31:0]        xsq_ff, oldsq_ff;
   logic [34:0]        base_ff;
   logic               rsp_valid_ff;
   lrn_rsp_type        rsp_data_ff;

   logic [ADDR_W-1:0]  old_addr, y_addr;
   logic [POS_W-1:0]   pos;
   logic               out_free, out_load, sum_we, store_we, norm_start, norm_done;
   logic signed [15:0] norm_value;
   logic [63:0]        lo_prod;
   logic [33:0]        hi_prod;
   logic [34:0]        term;

   assign pos      = cmd_ff.pos[POS_W-1:0];
   assign old_addr = ADDR_W'(cmd_ff.old_slot) * ADDR_W'(PLANE_MAX) + ADDR_W'(pos);
   assign y_addr   = ADDR_W'(cmd_ff.y_slot) * ADDR_W'(PLANE_MAX) + ADDR_W'(pos);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:   if (!fifo_empty) state_in = B_READ;
         B_READ:   state_in = B_SQUARE;
         B_SQUARE: state_in = B_SUM;
         B_SUM:    state_in = cmd_ff.emit ? B_BASE : B_IDLE;
         B_BASE:   state_in = B_START;
         B_START:  state_in = B_NORM;
         B_NORM:   if (norm_done) state_in = B_OUT;
         B_OUT:    if (out_free) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      fifo_pop   = (state_ff == B_IDLE) && !fifo_empty;
      store_we   = (state_ff == B_READ) && !cmd_ff.is_drain;
      sum_we     = (state_ff == B_SUM);
      norm_start = (state_ff == B_START);
      out_load   = (state_ff == B_OUT) && out_free;
   end

   always_comb begin
      sum_in = (cmd_ff.first ? 34'd0 : s_rd_ff)
             + (cmd_ff.is_drain ? 34'd0 : 34'(xsq_ff))
             - (cmd_ff.old_valid ? 34'(oldsq_ff) : 34'd0);
      lo_prod = 64'(coef.alpha_scale) * 64'(sum_ff[31:0]);
      hi_prod = 34'(coef.alpha_scale) * 34'(sum_ff[33:32]);
      term    = 35'(hi_prod) + 35'(lo_prod[63:32]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) cmd_ff <= cmd;
      if (state_ff == B_SQUARE) begin
         xsq_ff   <= 32'(cmd_ff.x * cmd_ff.x);
         oldsq_ff <= 32'(old_rd_ff * old_rd_ff);
         y_ff     <= cmd_ff.y_is_x ? cmd_ff.x : y_rd_ff;
      end
      if (sum_we) sum_ff <= sum_in;
      if (state_ff == B_BASE) base_ff <= 35'(coef.bias_k) + term;
      if (out_load) begin
         rsp_data_ff.value <= norm_value;
         rsp_data_ff.last  <= cmd_ff.last;
      end
   end

   // plane ring: read old and centre samples, write the new sample
   always_ff @(posedge clock) begin
      if (state_ff == B_READ) begin
         old_rd_ff <= store_mem[old_addr];
         y_rd_ff   <= store_mem[y_addr];
      end
      if (store_we) store_mem[old_addr] <= cmd_ff.x;
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_READ) s_rd_ff <= sums_mem[pos];
      if (sum_we) sums_mem[pos] <= sum_in;
   end

   lrn_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .x     (y_ff),
      .base  (base_ff),
      .beta  (coef.beta_exponent),
      .done  (norm_done),
      .value (norm_value)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_done_in_norm: assert property (@(posedge clock) disable iff (reset)
      norm_done |-> state_ff == B_NORM)
      else $error("power unit finished outside the wait state");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded result not presented");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |=> state_ff == B_READ)
      else $error("command popped without being processed");

endmodule

`default_nettype wire

@@ tb/tb_cross_channel_lrn.sv @@
`timescale 1ns / 1ps

module tb_cross_channel_lrn;
   import lrn_pkg::*;

   localparam int PMAX      = 4096;
   localparam int HMAX      = 4;
   localparam int RING_CAP  = 2 * HMAX + 1;
   localparam int NLOG      = 24;
   localparam int IDLE_GAP  = 120;   // a non-emitting transaction may still be in flight
   localparam int STALL_CAP = 5000;  // cycles without any transaction before giving up

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   lrn_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   lrn_rsp_type rsp_data;

   cross_channel_lrn dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // clock and one reset pulse at the start
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // shadow of the normaliser: register copies, plane ring and running sums
   // ---------------------------------------------------------------------------
   logic [12:0] sh_channels, sh_plane;
   logic [3:0]  sh_window;
   logic [31:0] sh_alpha;
   logic [17:0] sh_beta;
   logic [23:0] sh_bias;

   shortint           ring_mem [RING_CAP*PMAX];
   longint unsigned   sum_sq   [PMAX];
   int unsigned       in_plane, in_pos, out_plane, out_pos;
   bit                tensor_in;
   longint unsigned   root_q30 [NLOG+1];

   lrn_rsp_type expected_q[$];
   int          errors;

   function automatic longint unsigned sqrt_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void restart_tensor();
      in_plane = 0; in_pos = 0; out_plane = 0; out_pos = 0;
      tensor_in = 1'b0;
   endfunction

   // x * base^-beta via log2 / exp2 with the block's truncations
   function automatic int scale_element(int x, longint unsigned base);
      int              msb, i;
      longint unsigned mt, g, ax, mag;
      longint          frac, lg, e, ip, f, s;
      if (x == 0) return 0;
      if (sh_beta == 0) return x;
      if (base == 0) return (x > 0) ? 32767 : -32768;
      msb = 0;
      mt  = base;
      while (mt > 1) begin
         mt = mt >> 1;
         msb++;
      end
      mt   = (msb >= 30) ? (base >> (msb - 30)) : (base << (30 - msb));
      frac = 0;
      for (i = 1; i <= NLOG; i++) begin
         mt = (mt * mt) >> 30;
         if (mt >= (64'd1 << 31)) begin
            mt   = mt >> 1;
            frac = frac | (64'sd1 << (NLOG - i));
         end
      end
      lg = longint'(msb - 16) * (64'sd1 << NLOG) + frac;
      e  = (-(longint'(sh_beta) * lg)) >>> 16;   // arithmetic shift floors
      ip = e >>> NLOG;
      f  = e - (ip <<< NLOG);
      g  = 64'd1 << 30;
      for (i = 1; i <= NLOG; i++)
         if (f[NLOG-i]) g = (g * root_q30[i]) >> 30;
      ax = (x < 0) ? longint'(-x) : longint'(x);
      if (ip >= 16) mag = 64'd1 << 20;
      else begin
         s = 30 - ip;
         if (s > 47) mag = 0;
         else mag = (ax * g + (64'd1 << (s - 1))) >> s;
      end
      if (x > 0) return (mag > 32767) ? 32767 : int'(mag);
      return (mag > 32768) ? -32768 : -int'(mag);
   endfunction

   // advance the shadow by one accepted transaction, queue any result it gives
   function automatic void lrn_advance(lrn_req_type r);
      int unsigned     depth, plane, half, ring, d, q, idx;
      int              x, y, old;
      longint unsigned tot, term, base;
      bit              last;
      lrn_rsp_type     rsp;
      depth = (sh_channels < 1) ? 1 : ((sh_channels > DEPTH_MAX) ? DEPTH_MAX : sh_channels);
      plane = (sh_plane < 1) ? 1 : ((sh_plane > PMAX) ? PMAX : sh_plane);
      half  = (sh_window / 2 > HMAX) ? HMAX : sh_window / 2;
      ring  = 2 * half + 1;
      if (r.kind == KIND_SAMPLE) begin
         if (tensor_in) return;
         x   = r.sample;
         d   = in_plane;
         q   = in_pos;
         idx = (d % ring) * PMAX + q;
         if (d == 0) sum_sq[q] = longint'(x * x);
         else begin
            sum_sq[q] += longint'(x * x);
            if (d >= ring) begin
               old = ring_mem[idx];
               sum_sq[q] -= longint'(old * old);
            end
         end
         ring_mem[idx] = shortint'(x);
         in_pos++;
         if (in_pos >= plane) begin
            in_pos = 0;
            in_plane++;
            if (in_plane >= depth) tensor_in = 1'b1;
         end
         if (d < half) return;
      end else begin
         if (!tensor_in) return;
         if (out_plane >= half + 1) begin
            old = ring_mem[((out_plane - half - 1) % ring) * PMAX + out_pos];
            sum_sq[out_pos] -= longint'(old * old);
         end
      end
      y    = ring_mem[(out_plane % ring) * PMAX + out_pos];
      tot  = sum_sq[out_pos];
      term = longint'(sh_alpha) * (tot >> 32)
           + ((longint'(sh_alpha) * (tot & 64'hFFFF_FFFF)) >> 32);
      base = longint'(sh_bias) + term;
      last = (out_plane == depth - 1) && (out_pos == plane - 1);
      rsp.value = 16'(scale_element(y, base));
      rsp.last  = last;
      expected_q.push_back(rsp);
      out_pos++;
      if (out_pos >= plane) begin
         out_pos = 0;
         out_plane++;
      end
      if (last) restart_tensor();
   endfunction

   // ---------------------------------------------------------------------------
   // sender with bursts and gaps
   // ---------------------------------------------------------------------------
   int  burst_left;
   bit  gaps_on;
   int  sent_items;
   int  quiet_cycles;

   task automatic send_item(input logic kind, input logic signed [15:0] smp);
      lrn_req_type it;
      int          gap;
      it.kind   = kind;
      it.sample = smp;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gaps_on    = ($urandom_range(0, 3) != 0);
         gap        = gaps_on ? $urandom_range(1, 9) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      lrn_advance(it);
      sent_items++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (expected_q.size() == 0);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   // the enable stays high across back-to-back writes, the caller drops it
   task automatic write_reg(input lrn_csr_type which, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= val;
      @(posedge clock);
      case (which)
         CSR_CHANNEL_COUNT: sh_channels = val[12:0];
         CSR_PLANE_SIZE:    sh_plane    = val[12:0];
         CSR_WINDOW_SIZE:   sh_window   = val[3:0];
         CSR_ALPHA_SCALE:   sh_alpha    = val;
         CSR_BETA_EXPONENT: sh_beta     = val[17:0];
         CSR_BIAS_K:        sh_bias     = val[23:0];
         default: ;
      endcase
      restart_tensor();
   endtask

   task automatic set_shape_coef(input logic [12:0] ch, input logic [12:0] ps,
                                 input logic [3:0] win, input logic [31:0] al,
                                 input logic [17:0] be, input logic [23:0] bk);
      go_idle();
      write_reg(CSR_CHANNEL_COUNT, 32'(ch));
      write_reg(CSR_PLANE_SIZE, 32'(ps));
      write_reg(CSR_WINDOW_SIZE, 32'(win));
      write_reg(CSR_ALPHA_SCALE, al);
      write_reg(CSR_BETA_EXPONENT, 32'(be));
      write_reg(CSR_BIAS_K, 32'(bk));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sd0;
         3:       return 16'($signed($urandom_range(0, 511)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // one whole tensor, then drains; with noise some stray drains and late samples
   task automatic run_tensor(input bit noisy);
      int unsigned depth, plane, half, n, k;
      depth = (sh_channels < 1) ? 1 : ((sh_channels > DEPTH_MAX) ? DEPTH_MAX : sh_channels);
      plane = (sh_plane < 1) ? 1 : ((sh_plane > PMAX) ? PMAX : sh_plane);
      half  = (sh_window / 2 > HMAX) ? HMAX : sh_window / 2;
      n     = depth * plane;
      for (k = 0; k < n; k++) begin
         if (noisy && $urandom_range(0, 15) == 0) send_item(KIND_DRAIN, 16'($urandom));
         send_item(KIND_SAMPLE, pick_sample());
      end
      n = (half < depth ? half : depth) * plane;
      for (k = 0; k < n; k++) begin
         if (noisy && $urandom_range(0, 7) == 0) send_item(KIND_SAMPLE, pick_sample());
         send_item(KIND_DRAIN, 16'($urandom));
      end
      if (noisy) send_item(KIND_DRAIN, 16'($urandom));   // nothing left to flush
   endtask

   // ---------------------------------------------------------------------------
   // receiver stall pattern and result checking
   // ---------------------------------------------------------------------------
   int stall_mode;
   int stall_tick;

   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 2) == 0);
         2:       rsp_stall <= ((stall_tick / 37) % 2 == 1);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      lrn_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("unexpected transaction value=%0d last=%0d", rsp_data.value, rsp_data.last);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_data.value);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side and no register write
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_CAP) begin
         $display("tb_cross_channel_lrn failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   task automatic test_reset_defaults();
      // single-element tensor: the sample is held back, the drain flushes it
      send_item(KIND_DRAIN, 16'sd0);          // drain with nothing taken in
      send_item(KIND_SAMPLE, 16'sh0180);
      send_item(KIND_SAMPLE, 16'sh0100);      // ignored, tensor already in
      send_item(KIND_DRAIN, 16'sd0);
   endtask

   task automatic test_edge_values();
      set_shape_coef(13'd3, 13'd2, 4'd3, 32'd429497, 18'd49152, 24'd131072);
      send_item(KIND_SAMPLE, 16'sh7FFF);
      send_item(KIND_SAMPLE, 16'sh8000);
      send_item(KIND_DRAIN, 16'sd0);          // too early
      send_item(KIND_SAMPLE, 16'sd0);
      send_item(KIND_SAMPLE, 16'sd1);
      send_item(KIND_SAMPLE, -16'sd1);
      send_item(KIND_SAMPLE, 16'sh4000);
      send_item(KIND_DRAIN, 16'sd0);
      send_item(KIND_DRAIN, 16'sd0);
      // beta zero passes samples through, even with zero base
      set_shape_coef(13'd2, 13'd1, 4'd1, 32'd0, 18'd0, 24'd0);
      run_tensor(1'b0);
      // zero base saturates toward the sign
      set_shape_coef(13'd2, 13'd2, 4'd1, 32'd0, 18'd65536, 24'd0);
      send_item(KIND_SAMPLE, 16'sd5);
      send_item(KIND_SAMPLE, -16'sd5);
      send_item(KIND_SAMPLE, 16'sd0);
      send_item(KIND_SAMPLE, 16'sh7FFF);
      // huge gain from a tiny base and the largest beta
      set_shape_coef(13'd1, 13'd2, 4'd0, 32'd0, 18'h3FFFF, 24'd1);
      send_item(KIND_SAMPLE, 16'sd3);
      send_item(KIND_SAMPLE, -16'sd3);
   endtask

   task automatic test_register_extremes();
      // clamping shapes with all-ones alpha and bias (beta all ones, then one), then default coefficients
      set_shape_coef(13'd0, 13'd0, 4'd15, 32'hFFFF_FFFF, 18'h3FFFF, 24'hFF_FFFF);
      run_tensor(1'b1);
      set_shape_coef(13'd12, 13'd3, 4'd15, 32'hFFFF_FFFF, 18'd1, 24'hFF_FFFF);
      run_tensor(1'b1);
      set_shape_coef(13'd6, 13'd20, 4'd9, 32'd429497, 18'd49152, 24'd131072);
      run_tensor(1'b0);
   endtask

   task automatic test_random_tensors();
      logic [12:0] ch, ps;
      while (sent_items < 850) begin
         ch = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191) % 24)
                                          : 13'($urandom_range(1, 10));
         ps = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 40))
                                          : 13'($urandom_range(1, 6));
         if (32'(ch) * 32'(ps) > 400) ch = 13'd2;
         set_shape_coef(ch, ps, 4'($urandom), $urandom,
                        ($urandom_range(0, 1) ? 18'($urandom) : 18'($urandom_range(0, 98304))),
                        24'($urandom));
         run_tensor($urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      errors     = 0;
      burst_left = 0;
      gaps_on    = 1'b0;
      sent_items = 0;
      stall_mode = 0;
      stall_tick = 0;
      quiet_cycles = 0;
      reset      = 1'b1;
      csr_wr_en  = 1'b0;
      csr_index  = 3'd0;
      csr_wdata  = 32'd0;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_stall  = 1'b0;
      sh_channels = CHANNEL_COUNT_RST;
      sh_plane    = PLANE_SIZE_RST;
      sh_window   = WINDOW_SIZE_RST;
      sh_alpha    = ALPHA_SCALE_RST;
      sh_beta     = BETA_EXPONENT_RST;
      sh_bias     = BIAS_K_RST;
      foreach (ring_mem[i]) ring_mem[i] = 0;
      foreach (sum_sq[i]) sum_sq[i] = 0;
      restart_tensor();
      root_q30[0] = 0;
      root_q30[1] = sqrt_floor(64'd2 << 60);
      for (int i = 2; i <= NLOG; i++) root_q30[i] = sqrt_floor(root_q30[i-1] << 30);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_edge_values();
      test_register_extremes();
      test_random_tensors();

      go_idle();
      if (errors == 0 && expected_q.size() == 0)
         $display("tb_cross_channel_lrn passed");
      else
         $display("tb_cross_channel_lrn failed");
      $finish;
   end

endmodule
